>>> design/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants, types and helpers of the size-class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

    localparam int NUM_CLASSES  = 6;
    localparam int FREE_DEPTH   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 16;   // power of two

    localparam int DATA_W   = 32;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = $clog2(FREE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * FREE_DEPTH;
    localparam int MEM_AW   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int COST_W   = DATA_W + 2;
    localparam int SUM_W    = COST_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] HEAP_RESET = 32'h0040_0000;

    typedef logic [CLASS_W-1:0]   t_class;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [FILL_W-1:0]    t_fill;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_class NO_CLASS = 3'd6;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_OOM        = 2'd1;
    localparam t_status ST_NO_CLASS   = 2'd2;
    localparam t_status ST_STACK_FULL = 2'd3;

    localparam t_cfg_idx CFG_HEAP_BASE  = 1'b0;
    localparam t_cfg_idx CFG_HEAP_LIMIT = 1'b1;

    localparam logic [DATA_W-1:0] CLASS_SIZE [NUM_CLASSES] = '{
        32'h0000_0040, 32'h0000_0400, 32'h0000_1000,
        32'h0000_4000, 32'h0004_0000, 32'h0008_0000
    };

    localparam logic [COST_W-1:0] ROUND_MASK = COST_W'(ALIGN_BYTES - 1);

    // header plus payload, rounded up to the alignment
    function automatic logic [COST_W-1:0] block_cost(input logic [DATA_W-1:0] eff);
        logic [COST_W-1:0] raw;
        raw = COST_W'(eff) + COST_W'(HEADER_BYTES) + ROUND_MASK;
        return raw & ~ROUND_MASK;
    endfunction

endpackage

`default_nettype wire

>>> design/size_class_block_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator_core
// Segregated free-list allocator: six size classes with LIFO free stacks in
// one stack memory, plus a bump heap for fresh blocks.
// ----------------------------------------------------------------------------
// Latency: the result strobe is high in the cycle right after the accepting
// edge; the popped address comes straight from the registered stack read.
// Throughput: one request per cycle; state and the stack memory port are
// updated at the accepting edge, so o_busy never rises.
// Reset clears counts, stack fills and the output strobe and loads the bump
// pointer and limit with 0x400000; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request channel
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire                          i_action,
    input  wire  [sca_pkg::DATA_W-1:0]   i_request_size,
    input  wire  [sca_pkg::DATA_W-1:0]   i_block_address,
    // result channel
    output logic                         o_strobe,
    output logic [sca_pkg::DATA_W-1:0]   o_result_address,
    output logic [sca_pkg::STATUS_W-1:0] o_status,
    output logic [sca_pkg::CLASS_W-1:0]  o_size_class,
    output logic [sca_pkg::DATA_W-1:0]   o_live_count,
    output logic [sca_pkg::DATA_W-1:0]   o_peak_count,
    // configuration channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [sca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [sca_pkg::DATA_W-1:0]   i_cfg_data
);

    localparam int NC = sca_pkg::NUM_CLASSES;

    // state
    logic [sca_pkg::DATA_W-1:0] r_bump, n_bump;
    logic [sca_pkg::DATA_W-1:0] r_limit, n_limit;
    sca_pkg::t_fill             r_fill [NC];
    logic [sca_pkg::DATA_W-1:0] r_live [NC];
    logic [sca_pkg::DATA_W-1:0] r_peak [NC];
    logic [sca_pkg::DATA_W-1:0] r_mem  [sca_pkg::MEM_DEPTH];
    logic [sca_pkg::DATA_W-1:0] r_mem_q;

    // result register
    logic                        r_valid;
    logic                        r_pop, n_pop;
    logic [sca_pkg::DATA_W-1:0]  r_addr, n_addr;
    sca_pkg::t_status            r_status, n_status;
    sca_pkg::t_class             r_class, n_class;
    logic [sca_pkg::DATA_W-1:0]  r_live_q, n_live_q;
    logic [sca_pkg::DATA_W-1:0]  r_peak_q, n_peak_q;

    logic                        accept;
    logic                        cfg_we;
    logic                        has_class;
    sca_pkg::t_class             cls_upper, cls_exact;
    sca_pkg::t_fill              fill_sel, n_fill_sel;
    logic [sca_pkg::DATA_W-1:0]  live_sel, peak_sel, n_live_sel, n_peak_sel;
    logic [sca_pkg::DATA_W-1:0]  eff;
    logic [sca_pkg::COST_W-1:0]  cost;
    logic [sca_pkg::SUM_W-1:0]   sum;
    logic                        mem_we, mem_re;
    logic [sca_pkg::MEM_AW-1:0]  mem_addr;
    logic                        fill_we, cnt_we;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // first class that holds the size, and exact match for frees
    always_comb begin
        cls_upper = sca_pkg::NO_CLASS;
        cls_exact = sca_pkg::NO_CLASS;
        for (int c = NC - 1; c >= 0; c--) begin
            if (i_request_size <= sca_pkg::CLASS_SIZE[c]) begin
                cls_upper = sca_pkg::CLASS_W'(c);
            end
            if (i_request_size == sca_pkg::CLASS_SIZE[c]) begin
                cls_exact = sca_pkg::CLASS_W'(c);
            end
        end
    end

    always_comb begin
        n_class   = (i_action == sca_pkg::ACT_FREE) ? cls_exact : cls_upper;
        has_class = (n_class != sca_pkg::NO_CLASS);
        fill_sel  = has_class ? r_fill[n_class] : '0;
        live_sel  = has_class ? r_live[n_class] : '0;
        peak_sel  = has_class ? r_peak[n_class] : '0;
        eff       = has_class ? sca_pkg::CLASS_SIZE[n_class] : i_request_size;
        cost      = sca_pkg::block_cost(eff);
        sum       = sca_pkg::SUM_W'(r_bump) + sca_pkg::SUM_W'(cost);

        n_fill_sel = fill_sel;
        n_live_sel = live_sel;
        n_peak_sel = peak_sel;
        n_bump     = r_bump;
        n_limit    = r_limit;
        n_pop      = 1'b0;
        n_addr     = '0;
        n_status   = sca_pkg::ST_OK;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = sca_pkg::MEM_AW'(n_class) * sca_pkg::MEM_AW'(sca_pkg::FREE_DEPTH)
                   + sca_pkg::MEM_AW'(fill_sel);

        if (i_action == sca_pkg::ACT_ALLOC) begin
            if (has_class) begin
                n_live_sel = live_sel + 1'b1;
                if (n_live_sel > peak_sel) begin
                    n_peak_sel = n_live_sel;
                end
            end
            if (has_class && fill_sel != '0) begin
                n_fill_sel = fill_sel - 1'b1;
                mem_re     = 1'b1;
                n_pop      = 1'b1;
                mem_addr   = sca_pkg::MEM_AW'(n_class) * sca_pkg::MEM_AW'(sca_pkg::FREE_DEPTH)
                           + sca_pkg::MEM_AW'(n_fill_sel);
            end else begin
                n_bump = sum[sca_pkg::DATA_W-1:0];
                if (sum > sca_pkg::SUM_W'(r_limit)) begin
                    n_status = sca_pkg::ST_OOM;
                end else begin
                    n_addr = r_bump + sca_pkg::DATA_W'(sca_pkg::HEADER_BYTES);
                end
            end
        end else begin
            if (!has_class) begin
                n_status = sca_pkg::ST_NO_CLASS;
            end else begin
                if (fill_sel < sca_pkg::FILL_W'(sca_pkg::FREE_DEPTH)) begin
                    mem_we     = 1'b1;
                    n_fill_sel = fill_sel + 1'b1;
                end else begin
                    n_status = sca_pkg::ST_STACK_FULL;
                end
                n_live_sel = live_sel - 1'b1;
            end
        end

        n_live_q = has_class ? n_live_sel : '0;
        n_peak_q = has_class ? n_peak_sel : '0;
        fill_we  = accept && has_class;
        cnt_we   = accept && has_class;

        if (accept == 1'b0) begin
            n_bump = r_bump;
        end
        if (cfg_we) begin
            unique case (i_cfg_index)
                sca_pkg::CFG_HEAP_BASE:  n_bump  = i_cfg_data;
                sca_pkg::CFG_HEAP_LIMIT: n_limit = i_cfg_data;
            endcase
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[mem_addr] <= i_block_address;
        end
        if (accept && mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump  <= sca_pkg::HEAP_RESET;
            r_limit <= sca_pkg::HEAP_RESET;
            r_valid <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                r_fill[c] <= '0;
                r_live[c] <= '0;
                r_peak[c] <= '0;
            end
        end else begin
            r_bump  <= n_bump;
            r_limit <= n_limit;
            r_valid <= accept;
            if (fill_we) begin
                r_fill[n_class] <= n_fill_sel;
            end
            if (cnt_we) begin
                r_live[n_class] <= n_live_sel;
                r_peak[n_class] <= n_peak_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop    <= n_pop;
            r_addr   <= n_addr;
            r_status <= n_status;
            r_class  <= n_class;
            r_live_q <= n_live_q;
            r_peak_q <= n_peak_q;
        end
    end

    assign o_strobe         = r_valid;
    assign o_result_address = r_pop ? r_mem_q : r_addr;
    assign o_status         = r_status;
    assign o_size_class     = r_class;
    assign o_live_count     = r_live_q;
    assign o_peak_count     = r_peak_q;

    // checks
    a_strobe_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_strobe)
        else $error("accepted beat produced no result");

    a_no_class_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_size_class == sca_pkg::NO_CLASS)
            |-> (o_live_count == '0 && o_peak_count == '0))
        else $error("counts reported without a class");

    a_fail_zero_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != sca_pkg::ST_OK) |-> (o_result_address == '0))
        else $error("nonzero address on failed or free request");

    a_full_has_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == sca_pkg::ST_STACK_FULL || o_status == sca_pkg::ST_OOM
                      || o_status == sca_pkg::ST_OK) && r_pop)
            |-> (o_size_class != sca_pkg::NO_CLASS && o_status == sca_pkg::ST_OK))
        else $error("stack pop without a class");

endmodule

`default_nettype wire
